// ===== design/rmpl_pkg.sv =====
package rmpl_pkg;

  localparam int Entries = 16;
  localparam int MaxMotif = 10;
  localparam int VectorDepth = 32;
  localparam int SlotW = 4;
  localparam int IdxW = 5;
  localparam int CntW = 6;
  localparam int BasesW = 30;
  localparam int PeriodW = 4;
  localparam int LenW = 16;
  localparam int PenW = 8;
  localparam int SrcW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;
  localparam int WordAddrW = 1 + SlotW + IdxW;

  localparam logic [1:0] ModeLoadKey = 2'd0;
  localparam logic [1:0] ModeLoadWord = 2'd1;
  localparam logic [1:0] ModeQuery = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgDefaultOpen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDefaultExtend = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgExtendEnable = 2'd2;

  localparam logic [SrcW-1:0] SrcExact = 2'd0;
  localparam logic [SrcW-1:0] SrcWild = 2'd1;
  localparam logic [SrcW-1:0] SrcDefault = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic               table_sel;
    logic [SlotW-1:0]   slot;
    logic [BasesW-1:0]  motif_bases;
    logic [PeriodW-1:0] motif_period;
    logic [CntW-1:0]    penalty_count;
    logic [IdxW-1:0]    penalty_index;
    logic [PenW-1:0]    penalty_value;
    logic [LenW-1:0]    repeat_length;
  } in_item_t;

  typedef struct packed {
    logic [PenW-1:0] open_penalty;
    logic [PenW-1:0] ext_penalty;
    logic [SrcW-1:0] open_source;
    logic [SrcW-1:0] extend_source;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [LenW-1:0]    dividend;
    logic [PeriodW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [LenW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [BasesW-1:0] base_mask(input logic [PeriodW-1:0] p);
    logic [BasesW-1:0] m;
    m = '0;
    for (int i = 0; i < MaxMotif; i++) begin
      if (i < int'(p)) m[3*i +: 3] = 3'b111;
    end
    return m;
  endfunction

  function automatic logic [BasesW-1:0] wild_bases(input logic [PeriodW-1:0] p);
    logic [BasesW-1:0] m;
    m = '0;
    for (int i = 0; i < MaxMotif; i++) begin
      if (i < int'(p)) m[3*i +: 3] = 3'd4;
    end
    return m;
  endfunction

endpackage

// ===== design/rmpl_divider.sv =====
module rmpl_divider (
  input  logic              clk,
  input  logic              rst,
  input  rmpl_pkg::div_req_t req,
  output rmpl_pkg::div_rsp_t rsp
);
  import rmpl_pkg::*;

  logic [LenW-1:0]    quo;
  logic [PeriodW:0]   rem;
  logic [PeriodW-1:0] dvs;
  logic [4:0]         cnt;
  logic               busy;
  logic               done;
  logic [PeriodW+1:0] trial;

  assign trial = {rem, quo[LenW-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'(LenW);
        quo <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (trial[PeriodW+1]) begin
          rem <= {rem[PeriodW-1:0], quo[LenW-1]};
          quo <= {quo[LenW-2:0], 1'b0};
        end else begin
          rem <= trial[PeriodW:0];
          quo <= {quo[LenW-2:0], 1'b1};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
endmodule

// ===== design/repeat_motif_penalty_lookup_unit.sv =====
// Sequence: a load or unused item goes straight to the output register; a query runs a
// 16-step shared divide, then per table up to 32 key compares on one comparator and a
// registered word read (the extend table only when enabled).
// Flow: one item at a time; the next item is taken in the cycle after its result moves
// into the output register.
// Reset: rst is synchronous active high; clears key valid bits, config registers, out_valid and control state.
module repeat_motif_penalty_lookup_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rmpl_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rmpl_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [rmpl_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rmpl_pkg::CfgDataW-1:0]  cfg_data
);
  import rmpl_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_WILD  = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_RWAIT = 8'b0010_0000,
    S_NEXT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  in_item_t item;
  out_item_t result;
  logic [PenW-1:0] dflt_open, dflt_ext;
  logic ext_en;

  logic [Entries-1:0] key_valid [2];
  logic [PeriodW-1:0] key_period [2][Entries];
  logic [BasesW-1:0]  key_bases [2][Entries];
  logic [CntW-1:0]    counts [2][Entries];
  logic [PenW-1:0]    words [2**WordAddrW];
  logic [PenW-1:0]    word_rd;
  logic [WordAddrW-1:0] rd_addr;

  logic              tsel;
  logic [SlotW:0]    scan;
  logic [SlotW-1:0]  hit_slot;
  logic [LenW-1:0]   quot;
  logic [PenW-1:0]   pen;
  logic [SrcW-1:0]   src;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [PeriodW-1:0] wp;
  logic [PeriodW-1:0] cmp_p;
  logic [BasesW-1:0]  cmp_b;
  logic               cmp_hit;
  logic [SlotW-1:0]   si;
  logic [CntW-1:0]    cnt;
  logic [IdxW-1:0]    widx;
  logic [CntW-1:0]    lc;

  rmpl_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign wp = (item.motif_period > PeriodW'(MaxMotif)) ? PeriodW'(MaxMotif)
                                                       : item.motif_period;
  assign si = scan[SlotW-1:0];
  assign cmp_p = (state == S_WILD) ? wp : item.motif_period;
  assign cmp_b = (state == S_WILD) ? wild_bases(wp)
                                   : (item.motif_bases & base_mask(wp));
  assign cmp_hit = key_valid[tsel][si] && key_period[tsel][si] == cmp_p &&
                   key_bases[tsel][si] == cmp_b;
  assign cnt = counts[tsel][hit_slot];
  assign widx = (CntW'(quot) >= cnt || quot[LenW-1:CntW] != '0) ?
                IdxW'(cnt - CntW'(1)) : IdxW'(quot);
  assign lc = (in_data.penalty_count == '0) ? CntW'(1) :
              (in_data.penalty_count > CntW'(VectorDepth)) ? CntW'(VectorDepth) :
              in_data.penalty_count;

  assign dreq.start = (state == S_IDLE) && in_valid;
  assign dreq.dividend = in_data.repeat_length;
  assign dreq.divisor = in_data.motif_period;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    word_rd <= words[rd_addr];
    if (state == S_IDLE && in_valid && in_data.mode == ModeLoadWord)
      words[{in_data.table_sel, in_data.slot, in_data.penalty_index}] <=
        in_data.penalty_value;
    if (state == S_IDLE && in_valid && in_data.mode == ModeLoadKey) begin
      key_period[in_data.table_sel][in_data.slot] <= in_data.motif_period;
      key_bases[in_data.table_sel][in_data.slot] <=
        in_data.motif_bases & base_mask(in_data.motif_period > PeriodW'(MaxMotif) ?
                                        PeriodW'(MaxMotif) : in_data.motif_period);
      counts[in_data.table_sel][in_data.slot] <= lc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      key_valid[0] <= '0;
      key_valid[1] <= '0;
      dflt_open <= '0;
      dflt_ext <= '0;
      ext_en <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgDefaultOpen:   dflt_open <= cfg_data;
          CfgDefaultExtend: dflt_ext <= cfg_data;
          CfgExtendEnable:  ext_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data;
          result <= '0;
          tsel <= 1'b0;
          scan <= '0;
          if (in_data.mode == ModeLoadKey)
            key_valid[in_data.table_sel][in_data.slot] <= 1'b1;
          state <= (in_data.mode == ModeQuery) ? S_DIV : S_OUT;
        end
        S_DIV: if (drsp.done) begin
          quot <= (item.motif_period == '0) ? '1 : drsp.quotient;
          state <= S_SCAN;
        end
        S_SCAN, S_WILD: begin
          if (cmp_hit) begin
            hit_slot <= si;
            src <= (state == S_WILD) ? SrcWild : SrcExact;
            state <= S_READ;
          end else if (scan == (SlotW+1)'(Entries - 1)) begin
            scan <= '0;
            if (state == S_SCAN) state <= S_WILD;
            else begin
              src <= SrcDefault;
              pen <= tsel ? dflt_ext : dflt_open;
              state <= S_NEXT;
            end
          end else scan <= scan + 1'b1;
        end
        S_READ: begin
          rd_addr <= {tsel, hit_slot, widx};
          state <= S_RWAIT;
        end
        S_RWAIT: state <= S_NEXT;
        S_NEXT: begin
          if (!tsel) begin
            result.open_penalty <= (src == SrcDefault) ? pen : word_rd;
            result.open_source <= src;
            result.ext_penalty <= dflt_ext;
            result.extend_source <= SrcDefault;
            scan <= '0;
            tsel <= 1'b1;
            state <= ext_en ? S_SCAN : S_OUT;
          end else begin
            result.ext_penalty <= (src == SrcDefault) ? pen : word_rd;
            result.extend_source <= src;
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_data <= result;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
